>>> src/multi_deque_with_splice_top_assert.svh
// Assertion macros shared by the RTL files.
`ifndef MULTI_DEQUE_WITH_SPLICE_TOP_ASSERT_SVH
`define MULTI_DEQUE_WITH_SPLICE_TOP_ASSERT_SVH

// Checks an implication on every clock edge, outside reset.
`define MDQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks a condition that holds in the cycle after a trigger.
`define MDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/mdq_pkg.sv
package mdq_pkg;

    localparam int NUM_QUEUES_DEF = 16;
    localparam int DEPTH_DEF      = 64;

    localparam int REQ_W  = 2;
    localparam int QID_W  = 4;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SPLICE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [QID_W-1:0]  target_queue;
        logic [QID_W-1:0]  source_queue;
        logic              use_back_end;
        logic [DATA_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] popped_value;
    } rsp_t;

    // Front-end classification carried with each request.
    typedef struct packed {
        logic tq_ok;
        logic sq_ok;
        logic same_q;
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SPL_RD,
        ST_SPL_WR,
        ST_RESP
    } be_state_t;

endpackage

>>> src/mdq_if.sv
interface mdq_req_if;
    import mdq_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mdq_rsp_if;
    import mdq_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/mdq_front.sv
module mdq_front #(
    parameter int NUM_QUEUES = mdq_pkg::NUM_QUEUES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    mdq_req_if.sink           req,
    output logic              q_valid,
    output mdq_pkg::req_t     q_req,
    output mdq_pkg::cls_t     q_cls,
    input  logic              q_pop
);
    import mdq_pkg::*;

    localparam int QD = 2;

    req_t              buf_req_reg [QD];
    cls_t              buf_cls_reg [QD];
    logic              wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic              push;
    cls_t              cls;

    assign req.ready = (cnt_reg != 2'(QD));
    assign push      = req.valid && req.ready;

    always_comb
    begin
        cls.tq_ok  = 32'(req.payload.target_queue) < NUM_QUEUES;
        cls.sq_ok  = 32'(req.payload.source_queue) < NUM_QUEUES;
        cls.same_q = req.payload.target_queue == req.payload.source_queue;
    end

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_req_reg[wp_reg] <= req.payload;
            buf_cls_reg[wp_reg] <= cls;
        end
    end

    assign q_valid = cnt_reg != '0;
    assign q_req   = buf_req_reg[rp_reg];
    assign q_cls   = buf_cls_reg[rp_reg];

`include "multi_deque_with_splice_top_assert.svh"
    `MDQ_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, q_pop, q_valid)
    `MDQ_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= 2'(QD))
    `MDQ_ASSERT_NEXT(a_full_stall, clk, rst_n, push && !q_pop && cnt_reg == 2'(QD-1),
        !req.ready)
endmodule

>>> src/mdq_back.sv
module mdq_back #(
    parameter int NUM_QUEUES = mdq_pkg::NUM_QUEUES_DEF,
    parameter int DEPTH      = mdq_pkg::DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  mdq_pkg::req_t     q_req,
    input  mdq_pkg::cls_t     q_cls,
    output logic              q_pop,
    mdq_rsp_if.source         rsp
);
    import mdq_pkg::*;

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = QW + PW;
    localparam int MD = NUM_QUEUES * (1 << PW);

    logic [DATA_W-1:0] mem [MD];
    logic [DATA_W-1:0] rd_data_reg;

    logic [PW-1:0] head_reg [NUM_QUEUES];
    logic [CW-1:0] count_reg [NUM_QUEUES];

    be_state_t state_reg, state_next;
    req_t      cur_reg, cur_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [DATA_W-1:0] pv_reg, pv_next;
    logic      out_valid_reg, out_valid_next;

    // Derived signals for the request at the queue head and for the held request.
    logic [QW-1:0] tq, sq, cq, sq_cur, tq_cur;
    logic [PW-1:0] th, sh, th_cur, sh_cur;
    logic [CW-1:0] tc, sc, tc_cur, sc_cur;
    logic          t_full, t_empty;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [DATA_W-1:0] mem_wd;

    logic          hd_we_t, hd_we_s;
    logic [PW-1:0] hd_t_next, hd_s_next;
    logic          ct_we_t, ct_we_s;
    logic [CW-1:0] ct_t_next, ct_s_next;

    logic          accept;

    assign tq     = QW'(q_req.target_queue);
    assign sq     = QW'(q_req.source_queue);
    assign th     = head_reg[tq];
    assign tc     = count_reg[tq];
    assign t_full = tc == CW'(DEPTH);
    assign t_empty = tc == '0;
    assign tq_cur = QW'(cur_reg.target_queue);
    assign sq_cur = QW'(cur_reg.source_queue);
    assign th_cur = head_reg[tq_cur];
    assign sh_cur = head_reg[sq_cur];
    assign tc_cur = count_reg[tq_cur];
    assign sc_cur = count_reg[sq_cur];
    assign sh     = sh_cur;
    assign sc     = sc_cur;
    assign cq     = tq_cur;

    function automatic logic [PW-1:0] ring(input logic [PW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {1'b0, CW'(h)} + {1'b0, off};
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] dec(input logic [PW-1:0] h);
        return (h == '0) ? PW'(DEPTH - 1) : h - 1'b1;
    endfunction

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] h);
        return (h == PW'(DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    // A new request may start in the same cycle that the previous result transfers.
    assign accept = (state_reg == ST_IDLE) && q_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (q_req.req_type == REQ_POP && q_cls.tq_ok && !t_empty)
                        state_next = ST_RD_WAIT;
                    else if (q_req.req_type == REQ_SPLICE && q_cls.tq_ok && q_cls.sq_ok
                             && !q_cls.same_q)
                        state_next = ST_SPL_RD;
                end
            end
            ST_RD_WAIT: state_next = ST_RESP;
            ST_SPL_RD:  state_next = (sc == '0) ? ST_IDLE : ST_SPL_WR;
            ST_SPL_WR:  state_next = ST_SPL_RD;
            ST_RESP:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        stat_next      = stat_reg;
        pv_next        = pv_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        q_pop          = 1'b0;
        mem_we = 1'b0; mem_re = 1'b0; mem_wa = '0; mem_ra = '0; mem_wd = q_req.push_value;
        hd_we_t = 1'b0; hd_we_s = 1'b0; hd_t_next = th; hd_s_next = sh;
        ct_we_t = 1'b0; ct_we_s = 1'b0; ct_t_next = tc; ct_s_next = sc;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    q_pop     = 1'b1;
                    cur_next  = q_req;
                    stat_next = ST_DONE;
                    pv_next   = '0;
                    case (q_req.req_type)
                        REQ_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (q_cls.tq_ok)
                            begin
                                if (t_full)
                                    stat_next = ST_FULL;
                                else
                                begin
                                    mem_we  = 1'b1;
                                    ct_we_t = 1'b1;
                                    ct_t_next = tc + 1'b1;
                                    if (q_req.use_back_end)
                                        mem_wa = {tq, ring(th, tc)};
                                    else
                                    begin
                                        hd_we_t   = 1'b1;
                                        hd_t_next = dec(th);
                                        mem_wa    = {tq, dec(th)};
                                    end
                                end
                            end
                        end
                        REQ_POP:
                        begin
                            if (!q_cls.tq_ok || t_empty)
                            begin
                                stat_next      = ST_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                mem_re    = 1'b1;
                                ct_we_t   = 1'b1;
                                ct_t_next = tc - 1'b1;
                                if (q_req.use_back_end)
                                    mem_ra = {tq, ring(th, tc - 1'b1)};
                                else
                                begin
                                    mem_ra    = {tq, th};
                                    hd_we_t   = 1'b1;
                                    hd_t_next = inc(th);
                                end
                            end
                        end
                        REQ_SPLICE:
                        begin
                            if (!(q_cls.tq_ok && q_cls.sq_ok && !q_cls.same_q))
                                out_valid_next = 1'b1;
                        end
                        default: out_valid_next = 1'b1;
                    endcase
                end
            end
            ST_RD_WAIT: ;
            ST_RESP:
            begin
                pv_next        = rd_data_reg;
                out_valid_next = 1'b1;
            end
            ST_SPL_RD:
            begin
                if (sc == '0)
                    out_valid_next = 1'b1;
                else
                begin
                    mem_re    = 1'b1;
                    ct_we_s   = 1'b1;
                    ct_s_next = sc - 1'b1;
                    if (cur_reg.use_back_end)
                        mem_ra = {sq_cur, ring(sh, sc - 1'b1)};
                    else
                    begin
                        mem_ra    = {sq_cur, sh};
                        hd_we_s   = 1'b1;
                        hd_s_next = inc(sh);
                    end
                end
            end
            ST_SPL_WR:
            begin
                mem_wd = rd_data_reg;
                if (tc_cur == CW'(DEPTH))
                    stat_next = ST_FULL;
                else
                begin
                    mem_we    = 1'b1;
                    mem_wa    = {cq, ring(th_cur, tc_cur)};
                    ct_we_t   = 1'b1;
                    ct_t_next = tc_cur + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // In splice states the target index comes from the held request.
    logic [QW-1:0] wq;
    assign wq = (state_reg == ST_IDLE) ? tq : tq_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (hd_we_t) head_reg[wq] <= hd_t_next;
            if (hd_we_s) head_reg[sq_cur] <= hd_s_next;
            if (ct_we_t) count_reg[wq] <= ct_t_next;
            if (ct_we_s) count_reg[sq_cur] <= ct_s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        stat_reg <= stat_next;
        pv_reg   <= pv_next;
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_ra];
    end

    assign rsp.valid                = out_valid_reg;
    assign rsp.payload.status       = stat_reg;
    assign rsp.payload.popped_value = pv_reg;

`include "multi_deque_with_splice_top_assert.svh"
    `MDQ_ASSERT_IMPL(a_pop_only_idle, clk, rst_n, q_pop, state_reg == ST_IDLE)
    `MDQ_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, 1'b1, !(mem_we && mem_re))
    `MDQ_ASSERT_NEXT(a_resp_follows, clk, rst_n, state_reg == ST_RESP, out_valid_reg)
endmodule

>>> src/multi_deque_with_splice_top.sv
// Push, rejected requests and empty pops are answered from the idle state; a successful
// pop passes a read-wait and a response state, set by the store's registered read; a
// splice alternates read and write states per moved entry. Throughput: one push or
// rejected request per cycle while results drain; pops and splices hold the back end.
// Reset: rst_n is asynchronous, active low; it empties every queue at once.
module multi_deque_with_splice_top #(
    parameter int NUM_QUEUES = mdq_pkg::NUM_QUEUES_DEF,
    parameter int DEPTH      = mdq_pkg::DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mdq_req_if.sink   req,
    mdq_rsp_if.source rsp
);
    import mdq_pkg::*;

    // The front end buffers up to two requests and tags each with range and same-queue checks,
    // so upstream transfers can continue while the back end is busy, until the buffer fills.
    logic q_valid, q_pop;
    req_t q_req;
    cls_t q_cls;

    mdq_front #(.NUM_QUEUES(NUM_QUEUES)) u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_valid(q_valid), .q_req(q_req), .q_cls(q_cls), .q_pop(q_pop)
    );

    // The back end owns the entry store, the head and count tables, and the
    // result register; it runs each request to completion, splices entry by entry.
    mdq_back #(.NUM_QUEUES(NUM_QUEUES), .DEPTH(DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_req(q_req), .q_cls(q_cls), .q_pop(q_pop),
        .rsp(rsp)
    );
endmodule
